>>> rtl/nbt_pkg.sv
// Shared types and constants for the nearest blob tracker.
// Holds the transaction payload structs, the blob table word and the fixed codes.
// No dependencies.
package nbt_pkg;

  localparam int COORD_W  = 14;
  localparam int AGE_W    = 3;
  localparam int RADIUS_W = 26;
  localparam int SLOT_W   = 4;
  localparam int LIVE_W   = 5;
  localparam int DIST_W   = 2 * COORD_W + 1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 26'd2304;
  localparam logic [AGE_W-1:0]    AGE_LIMIT_RESET = 3'd5;
  localparam logic [AGE_W-1:0]    AGE_MAX         = 3'd7;

  // func codes
  localparam logic FUNC_DETECT = 1'b0;
  localparam logic FUNC_EOF    = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_AGE    = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              is_new;
    logic              dropped;
    logic [LIVE_W-1:0] live_count;
  } out_item_t;

  // one word of the blob table memory
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [AGE_W-1:0]   age;
  } blob_t;

endpackage

>>> rtl/nearest_blob_tracker.sv
// Nearest-neighbor blob tracker: top level with the blob table memory and scan pipeline.
// Depends on nbt_pkg (payload structs, table word, codes).
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one transaction per item: a
//   detection (func = FUNC_DETECT) with a Q10.4 centroid, or an end-of-frame marker.
//   Output channel (out_valid/out_ready/out_data) returns exactly one transaction per
//   item: the matched or allocated slot, is_new, dropped and the live blob count.
//   Configuration goes through the APB-style port: match_radius_sq at 0x0, age_limit
//   at 0x4. pready is tied high; write only while the block is idle.
// Timing:
//   Every item sweeps the whole table through the single read port of the blob
//   memory, one slot per cycle, then drains a two-stage distance pipeline and
//   commits in the decide state. One item is in work at a time: a new item is
//   taken only once the last one has left the decide state.
// Reset:
//   Clears the valid and paired bits, the live count, the pipeline and both
//   registers to their defaults. The memory is not cleared; only live slots' data is used.
// Stall:
//   The result sits in an output register. A new item is taken while it waits;
//   that item's decide cycle holds until the output register is free.
module nearest_blob_tracker #(
  parameter int MAX_BLOBS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nbt_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOBS + 1);
  localparam int CW    = nbt_pkg::COORD_W;
  localparam int AW    = nbt_pkg::AGE_W;
  localparam int DW    = nbt_pkg::DIST_W;
  localparam int RW    = nbt_pkg::RADIUS_W;
  localparam int SLW   = nbt_pkg::SLOT_W;
  localparam int LVW   = nbt_pkg::LIVE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOBS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BLOBS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  // ---------------------------------------------------------------- registers
  logic [1:0]               state_r;
  nbt_pkg::in_item_t        item_r;
  logic [IDX_W-1:0]         idx_r;
  logic [RW-1:0]            radius_r;
  logic [AW-1:0]            age_lim_r;
  logic [MAX_BLOBS-1:0]     slot_valid_r;
  logic [MAX_BLOBS-1:0]     paired_r;
  logic [CNT_W-1:0]         live_cnt_r;
  logic [CNT_W-1:0]         live_cnt_nxt;

  // blob table memory: x, y and age of each slot
  nbt_pkg::blob_t           mem [MAX_BLOBS];
  nbt_pkg::blob_t           mem_rdata_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  nbt_pkg::blob_t           mem_wdata;

  // stage 1: read data back, stage 2: distance sum and nearest search
  logic                     s1_v_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s2_v_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic [AW-1:0]            s2_age_r;
  logic [2*CW-1:0]          sqx_r;
  logic [2*CW-1:0]          sqy_r;

  logic                     found_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [DW-1:0]            best_d_r;
  logic [AW-1:0]            best_age_r;
  logic                     free_found_r;
  logic [IDX_W-1:0]         free_idx_r;

  logic                     out_valid_r;
  nbt_pkg::out_item_t       out_data_r;

  // ---------------------------------------------------------------- control
  logic                     in_fire;
  logic                     is_detect;
  logic                     out_free;
  logic                     fire;
  logic                     is_match;
  logic                     do_alloc;
  nbt_pkg::out_item_t       res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_detect = (item_r.func == nbt_pkg::FUNC_DETECT);
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = (state_r == ST_DECIDE) && out_free;
  assign is_match  = found_r && (best_d_r < DW'(radius_r));
  assign do_alloc  = !is_match && free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_SCAN;
            idx_r   <= '0;
          end
        end
        ST_SCAN: begin
          // issue one table read per cycle
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_SCAN) begin
      mem_rdata_r <= mem[idx_r];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic          s1_live;
  logic          s1_paired;
  logic          age_over;
  logic          eof_act;
  logic          eof_free;
  logic          eof_inc;

  assign dx = (mem_rdata_r.x > item_r.centroid_x) ? mem_rdata_r.x - item_r.centroid_x
                                                  : item_r.centroid_x - mem_rdata_r.x;
  assign dy = (mem_rdata_r.y > item_r.centroid_y) ? mem_rdata_r.y - item_r.centroid_y
                                                  : item_r.centroid_y - mem_rdata_r.y;

  // end of frame: age or free the slot whose data just came back, write back in place
  assign s1_live   = slot_valid_r[s1_idx_r];
  assign s1_paired = paired_r[s1_idx_r];
  assign age_over  = mem_rdata_r.age > age_lim_r;
  assign eof_act   = s1_v_r && !is_detect && s1_live;
  assign eof_free  = eof_act && age_over && !s1_paired;
  assign eof_inc   = eof_act && !age_over && (mem_rdata_r.age != nbt_pkg::AGE_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ST_SCAN);
      s2_v_r <= s1_v_r && is_detect;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= idx_r;
    s2_idx_r <= s1_idx_r;
    s2_age_r <= mem_rdata_r.age;
    sqx_r    <= (2*CW)'(dx) * (2*CW)'(dx);
    sqy_r    <= (2*CW)'(dy) * (2*CW)'(dy);
  end

  // ---------------------------------------------------------------- stage 2
  logic [DW-1:0] dist_sum;
  assign dist_sum = DW'(sqx_r) + DW'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (in_fire) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (s2_v_r) begin
      // valid bits are static during a detection sweep; strict compare keeps the lowest tie
      if (slot_valid_r[s2_idx_r]) begin
        if (!found_r || dist_sum < best_d_r) begin
          found_r <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      if (slot_valid_r[s2_idx_r]) begin
        if (!found_r || dist_sum < best_d_r) begin
          best_idx_r <= s2_idx_r;
          best_d_r   <= dist_sum;
          best_age_r <= s2_age_r;
        end
      end else if (!free_found_r) begin
        free_idx_r <= s2_idx_r;
      end
    end
  end

  // ---------------------------------------------------------------- write-back
  // Reads and writes never hit the same slot in the same cycle: the sweep writes only the
  // slot one behind the read pointer, and the decide cycle writes after the sweep.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_idx_r;
    mem_wdata = mem_rdata_r;
    if (eof_inc) begin
      mem_we        = 1'b1;
      mem_wdata.age = mem_rdata_r.age + 1'b1;
    end else if (fire && is_detect && is_match) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_r;
      mem_wdata = '{x: item_r.centroid_x, y: item_r.centroid_y, age: best_age_r};
    end else if (fire && is_detect && do_alloc) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx_r;
      mem_wdata = '{x: item_r.centroid_x, y: item_r.centroid_y, age: '0};
    end
  end

  always_comb begin
    live_cnt_nxt = live_cnt_r;
    if (eof_free) begin
      live_cnt_nxt = live_cnt_r - 1'b1;
    end else if (fire && is_detect && do_alloc) begin
      live_cnt_nxt = live_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      paired_r     <= '0;
      live_cnt_r   <= '0;
    end else begin
      live_cnt_r <= live_cnt_nxt;
      if (eof_free) begin
        slot_valid_r[s1_idx_r] <= 1'b0;
      end
      if (fire) begin
        if (!is_detect) begin
          // drop all paired marks at the end of the frame
          paired_r <= '0;
        end else if (is_match) begin
          paired_r[best_idx_r] <= 1'b1;
        end else if (do_alloc) begin
          paired_r[free_idx_r]     <= 1'b1;
          slot_valid_r[free_idx_r] <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    res            = '0;
    res.live_count = LVW'(live_cnt_nxt);
    if (is_detect) begin
      if (is_match) begin
        res.slot = SLW'(best_idx_r);
      end else if (do_alloc) begin
        res.slot   = SLW'(free_idx_r);
        res.is_new = 1'b1;
      end else begin
        res.dropped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= nbt_pkg::RADIUS_RESET;
      age_lim_r <= nbt_pkg::AGE_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        nbt_pkg::REG_RADIUS: radius_r  <= pwdata[RW-1:0];
        nbt_pkg::REG_AGE:    age_lim_r <= pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nbt_pkg::REG_RADIUS: prdata = 32'(radius_r);
      nbt_pkg::REG_AGE:    prdata = 32'(age_lim_r);
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------------------------------------------------------- assertions
  a_live_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r == CNT_W'($countones(slot_valid_r)))
    else $error("live count out of step with valid bits");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.dropped) |-> (live_cnt_r == FULL_CNT))
    else $error("detection dropped with a free slot");

  a_new_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.is_new && out_data_r.dropped))
    else $error("result both allocated and dropped");

  a_no_valid_change_in_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && $past(s2_v_r)) |-> $stable(slot_valid_r))
    else $error("valid bits changed during a detection sweep");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_blob_tracker: a directed stimulus table, then random frames.
// Depends on nbt_pkg and the tracker RTL; reports are predicted from a private blob table or typed in the table.
module testbench;

  localparam int COORD_W  = nbt_pkg::COORD_W;
  localparam int AGE_W    = nbt_pkg::AGE_W;
  localparam int RADIUS_W = nbt_pkg::RADIUS_W;
  localparam int SLOT_W   = nbt_pkg::SLOT_W;
  localparam int LIVE_W   = nbt_pkg::LIVE_W;
  localparam int DIST_W   = nbt_pkg::DIST_W;

  localparam int NUM_SLOTS    = 16;
  localparam int WATCHDOG_MAX = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 178;
  localparam int NUM_PHASES   = 8;
  localparam logic [COORD_W-1:0]  COORD_TOP  = '1;
  localparam logic [RADIUS_W-1:0] RADIUS_TOP = '1;

  typedef enum logic { ROW_ITEM, ROW_CONFIG } row_kind_t;

  // One line of the directed table: either a transaction or a register setting.
  typedef struct {
    row_kind_t           kind;
    nbt_pkg::in_item_t   item;
    bit                  has_exp;
    nbt_pkg::out_item_t  exp;
    logic [RADIUS_W-1:0] radius;
    logic [AGE_W-1:0]    limit;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  nbt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nbt_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Private copy of the blob table and the two registers.
  logic                tbl_live   [NUM_SLOTS];
  logic [COORD_W-1:0]  tbl_x      [NUM_SLOTS];
  logic [COORD_W-1:0]  tbl_y      [NUM_SLOTS];
  logic                tbl_paired [NUM_SLOTS];
  logic [AGE_W-1:0]    tbl_age    [NUM_SLOTS];
  logic [RADIUS_W-1:0] radius_sq;
  logic [AGE_W-1:0]    age_lim;

  nbt_pkg::out_item_t report_q[$];   // reports still owed by the tracker, oldest first
  stim_row_t          dir_rows[$];
  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  nearest_blob_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Advance the private table by one transaction and return the report it causes.
  function automatic nbt_pkg::out_item_t track_blobs(nbt_pkg::in_item_t it);
    nbt_pkg::out_item_t  rep;
    logic                found;
    int                  best;
    int                  free_slot;
    logic [COORD_W-1:0]  dx;
    logic [COORD_W-1:0]  dy;
    logic [DIST_W-1:0]   dxw;
    logic [DIST_W-1:0]   dyw;
    logic [DIST_W-1:0]   d_sq;
    logic [DIST_W-1:0]   best_d;
    logic [LIVE_W-1:0]   live;
    rep       = '0;
    found     = 1'b0;
    best      = 0;
    best_d    = '0;
    free_slot = -1;
    live      = '0;
    if (it.func == nbt_pkg::FUNC_EOF) begin
      // Age young blobs (saturating), free old unpaired ones, clear all paired marks.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tbl_live[i]) begin
          if (tbl_age[i] > age_lim) begin
            if (!tbl_paired[i]) tbl_live[i] = 1'b0;
          end else if (tbl_age[i] < nbt_pkg::AGE_MAX) begin
            tbl_age[i] = tbl_age[i] + 1'b1;
          end
        end
        tbl_paired[i] = 1'b0;
      end
    end else begin
      // Nearest live slot by squared distance; strict less-than keeps the lowest on a tie.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tbl_live[i]) begin
          dx   = (tbl_x[i] > it.centroid_x) ? tbl_x[i] - it.centroid_x
                                            : it.centroid_x - tbl_x[i];
          dy   = (tbl_y[i] > it.centroid_y) ? tbl_y[i] - it.centroid_y
                                            : it.centroid_y - tbl_y[i];
          dxw  = dx;
          dyw  = dy;
          d_sq = dxw * dxw + dyw * dyw;
          if (!found || d_sq < best_d) begin
            found  = 1'b1;
            best   = i;
            best_d = d_sq;
          end
        end
      end
      if (found && best_d < radius_sq) begin
        tbl_x[best]      = it.centroid_x;
        tbl_y[best]      = it.centroid_y;
        tbl_paired[best] = 1'b1;
        rep.slot         = best[SLOT_W-1:0];
      end else begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!tbl_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          rep.dropped = 1'b1;
        end else begin
          tbl_live[free_slot]   = 1'b1;
          tbl_x[free_slot]      = it.centroid_x;
          tbl_y[free_slot]      = it.centroid_y;
          tbl_paired[free_slot] = 1'b1;
          tbl_age[free_slot]    = '0;
          rep.slot              = free_slot[SLOT_W-1:0];
          rep.is_new            = 1'b1;
        end
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_live[i]) live = live + 1'b1;
    end
    rep.live_count = live;
    return rep;
  endfunction

  // Pick a detection: mostly a jittered copy of a live blob, else anywhere, else a corner.
  function automatic nbt_pkg::in_item_t make_detection();
    nbt_pkg::in_item_t it;
    int                live_slots[$];
    int                pick;
    int                roll;
    int                jx;
    int                jy;
    int                nx;
    int                ny;
    it      = '0;
    it.func = nbt_pkg::FUNC_DETECT;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_live[i]) live_slots = {live_slots, i};
    end
    roll = $urandom_range(99);
    if (roll < 60 && live_slots.size() > 0) begin
      pick = live_slots[$urandom_range(live_slots.size() - 1)];
      jx   = $urandom_range(128);
      jy   = $urandom_range(128);
      nx   = int'(tbl_x[pick]) + jx - 64;
      ny   = int'(tbl_y[pick]) + jy - 64;
      if (nx < 0) nx = 0;
      if (ny < 0) ny = 0;
      if (nx > int'(COORD_TOP)) nx = int'(COORD_TOP);
      if (ny > int'(COORD_TOP)) ny = int'(COORD_TOP);
      it.centroid_x = nx[COORD_W-1:0];
      it.centroid_y = ny[COORD_W-1:0];
    end else if (roll < 88) begin
      it.centroid_x = COORD_W'($urandom);
      it.centroid_y = COORD_W'($urandom);
    end else begin
      it.centroid_x = $urandom_range(1) ? COORD_TOP : '0;
      it.centroid_y = $urandom_range(1) ? COORD_TOP : '0;
    end
    return it;
  endfunction

  task automatic add_row(logic func, int x, int y, bit has_exp,
                         int slot, bit is_new, bit dropped, int live);
    stim_row_t row;
    row.kind            = ROW_ITEM;
    row.item.func       = func;
    row.item.centroid_x = x[COORD_W-1:0];
    row.item.centroid_y = y[COORD_W-1:0];
    row.has_exp         = has_exp;
    row.exp.slot        = slot[SLOT_W-1:0];
    row.exp.is_new      = is_new;
    row.exp.dropped     = dropped;
    row.exp.live_count  = live[LIVE_W-1:0];
    row.radius          = '0;
    row.limit           = '0;
    dir_rows            = {dir_rows, row};
  endtask

  task automatic add_cfg_row(logic [RADIUS_W-1:0] radius, logic [AGE_W-1:0] limit);
    stim_row_t row;
    row.kind    = ROW_CONFIG;
    row.item    = '0;
    row.has_exp = 1'b0;
    row.exp     = '0;
    row.radius  = radius;
    row.limit   = limit;
    dir_rows    = {dir_rows, row};
  endtask

  // One APB transfer. psel stays high at the end so transfers can run back to back;
  // the caller drops it when the bus goes idle.
  task automatic apb_transfer(logic idx, logic wr, logic [31:0] data,
                              output logic [31:0] rdata);
    logic ready_seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      // Sample mid-cycle, away from the edge that completes the transfer.
      @(negedge clk);
      rdata      = prdata;
      ready_seen = pready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  // Write a register, then read it back and compare the implemented bits.
  task automatic write_register(logic idx, logic [31:0] value);
    logic [31:0] rd;
    logic        bad;
    apb_transfer(idx, 1'b1, value, rd);
    apb_transfer(idx, 1'b0, 32'd0, rd);
    if (idx == nbt_pkg::REG_RADIUS) bad = (rd[RADIUS_W-1:0] !== value[RADIUS_W-1:0]);
    else                            bad = (rd[AGE_W-1:0] !== value[AGE_W-1:0]);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10)
        $display("register %0d readback: wrote 0x%0h, read 0x%0h", idx, value, rd);
    end
  endtask

  task automatic set_tracking(logic [RADIUS_W-1:0] radius, logic [AGE_W-1:0] limit);
    write_register(nbt_pkg::REG_RADIUS, 32'(radius));
    write_register(nbt_pkg::REG_AGE, 32'(limit));
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    radius_sq  = radius;
    age_lim    = limit;
  endtask

  // Drop valid and hold off until every owed report has come back.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
  endtask

  // Present one transaction, hold it until accepted, then log what it must produce.
  task automatic send_item(nbt_pkg::in_item_t it, bit has_exp,
                           nbt_pkg::out_item_t typed_exp);
    nbt_pkg::out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    pred     = track_blobs(it);
    report_q = {report_q, (has_exp ? typed_exp : pred)};
  endtask

  // Receiver: stall at the phase's rate.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted report with the oldest one owed.
  always @(posedge clk) begin
    nbt_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected report: slot %0d new %0b drop %0b live %0d",
                   out_data.slot, out_data.is_new, out_data.dropped, out_data.live_count);
      end else begin
        want = report_q.pop_front();
        if (out_data.slot !== want.slot || out_data.is_new !== want.is_new ||
            out_data.dropped !== want.dropped || out_data.live_count !== want.live_count) begin
          fail_count++;
          if (fail_count <= 10) begin
            $write("report mismatch: exp slot %0d new %0b drop %0b live %0d, ",
                   want.slot, want.is_new, want.dropped, want.live_count);
            $display("got slot %0d new %0b drop %0b live %0d",
                     out_data.slot, out_data.is_new, out_data.dropped, out_data.live_count);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no transaction on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    nbt_pkg::in_item_t   item;
    logic [RADIUS_W-1:0] rad;
    logic [AGE_W-1:0]    lim;
    int                  sent;
    int                  n_det;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    // Mirror the reset state: empty table, default registers.
    radius_sq = nbt_pkg::RADIUS_RESET;
    age_lim   = nbt_pkg::AGE_LIMIT_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_live[i]   = 1'b0;
      tbl_paired[i] = 1'b0;
      tbl_x[i]      = '0;
      tbl_y[i]      = '0;
      tbl_age[i]    = '0;
    end

    // Directed table, reset registers first (radius squared 2304, age limit 5).
    add_row(nbt_pkg::FUNC_EOF,    0,     0,     1, 0, 0, 0, 0);  // end of frame, empty table
    add_row(nbt_pkg::FUNC_DETECT, 0,     0,     1, 0, 1, 0, 1);  // empty table allocates
    add_row(nbt_pkg::FUNC_DETECT, 16383, 16383, 1, 1, 1, 0, 2);  // far corner allocates
    add_row(nbt_pkg::FUNC_DETECT, 47,    0,     0, 0, 0, 0, 0);  // just inside the radius
    add_row(nbt_pkg::FUNC_DETECT, 95,    0,     0, 0, 0, 0, 0);  // exactly on the radius
    add_row(nbt_pkg::FUNC_DETECT, 71,    0,     0, 0, 0, 0, 0);  // tie, paired blob again
    for (int k = 1; k <= 13; k++)
      add_row(nbt_pkg::FUNC_DETECT, 1000 * k, 5000, 0, 0, 0, 0, 0);  // fill the table
    add_row(nbt_pkg::FUNC_DETECT, 8000,  12000, 1, 0, 0, 1, 16); // full table drops
    add_row(nbt_pkg::FUNC_EOF,    0,     0,     1, 0, 0, 0, 16); // every blob ages
    add_cfg_row('0, '0);
    add_row(nbt_pkg::FUNC_DETECT, 71,    0,     1, 0, 0, 1, 16); // zero radius never matches
    add_row(nbt_pkg::FUNC_EOF,    16383, 16383, 1, 0, 0, 0, 0);  // old and unpaired: freed
    add_row(nbt_pkg::FUNC_DETECT, 16383, 0,     1, 0, 1, 0, 1);
    add_cfg_row(RADIUS_TOP, nbt_pkg::AGE_MAX);
    add_row(nbt_pkg::FUNC_DETECT, 0,     16383, 0, 0, 0, 0, 0);  // beyond the widest radius
    add_row(nbt_pkg::FUNC_DETECT, 12000, 4000,  0, 0, 0, 0, 0);  // long-distance match
    add_row(nbt_pkg::FUNC_EOF,    0,     0,     0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table at full rate; settings only with the block idle.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CONFIG) begin
        drain_reports();
        set_tracking(dir_rows[r].radius, dir_rows[r].limit);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].has_exp, dir_rows[r].exp);
      end
    end

    // Random frames: each phase picks a register setting and an idling pattern.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_reports();
      case (phase)
        0: begin
          rad = nbt_pkg::RADIUS_RESET;
          lim = nbt_pkg::AGE_LIMIT_RESET;
        end
        1:       begin rad = '0;          lim = '0;               end
        2:       begin rad = RADIUS_TOP;  lim = nbt_pkg::AGE_MAX; end
        3:       begin rad = nbt_pkg::RADIUS_RESET; lim = nbt_pkg::AGE_MAX; end
        4: begin
          rad = RADIUS_W'($urandom_range(20000));
          lim = AGE_W'($urandom_range(7));
        end
        5:       begin rad = 26'd4096;    lim = 3'd1;             end
        6: begin
          rad = RADIUS_W'($urandom);
          lim = AGE_W'($urandom_range(7));
        end
        default: begin rad = 26'd9000;    lim = 3'd3;             end
      endcase
      set_tracking(rad, lim);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short frames; now and then a crowd that fills the table.
        n_det = ($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(5);
        repeat (n_det) begin
          send_item(make_detection(), 1'b0, '0);
          sent++;
        end
        // Leave out the end of frame now and then so frames run together.
        if ($urandom_range(9) != 0) begin
          item.func       = nbt_pkg::FUNC_EOF;
          item.centroid_x = COORD_W'($urandom);
          item.centroid_y = COORD_W'($urandom);
          send_item(item, 1'b0, '0);
          sent++;
        end
      end
    end

    // Let everything owed come back, then idle a little longer to catch strays.
    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      fail_count += report_q.size();
      $display("%0d reports never arrived", report_q.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
